>>> design/vn2o_pkg.sv
// ----------------------------------------------------------------------------
// vn2o_pkg
// Shared types and constants of the fractal 2D value noise core: the lattice
// permutation ROM, the seed offset, register indexes and the reciprocal table
// used by the normalizer.
// ----------------------------------------------------------------------------
package vn2o_pkg;

    // register indexes of the configuration port
    localparam logic REG_FREQUENCY = 1'b0;
    localparam logic REG_OCTAVES   = 1'b1;

    localparam logic [23:0] FREQ_RESET    = 24'd65536;
    localparam logic [3:0]  OCTAVES_RESET = 4'd4;

    // low byte of the hash seed 276327645
    localparam logic [7:0] SEED_OFS = 8'd221;

    localparam int POINT_W = 40;

    typedef logic [POINT_W-1:0] point_t;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd208, 8'd34, 8'd231, 8'd213, 8'd32, 8'd248, 8'd233, 8'd56,
        8'd161, 8'd78, 8'd24, 8'd140, 8'd71, 8'd48, 8'd140, 8'd254,
        8'd245, 8'd255, 8'd247, 8'd247, 8'd40, 8'd185, 8'd248, 8'd251,
        8'd245, 8'd28, 8'd124, 8'd204, 8'd204, 8'd76, 8'd36, 8'd1,
        8'd107, 8'd28, 8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
        8'd167, 8'd204, 8'd9, 8'd92, 8'd217, 8'd54, 8'd239, 8'd174,
        8'd173, 8'd102, 8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108,
        8'd167, 8'd44, 8'd43, 8'd77, 8'd180, 8'd204, 8'd8, 8'd81,
        8'd70, 8'd223, 8'd11, 8'd38, 8'd24, 8'd254, 8'd210, 8'd210,
        8'd177, 8'd32, 8'd81, 8'd195, 8'd243, 8'd125, 8'd8, 8'd169,
        8'd112, 8'd32, 8'd97, 8'd53, 8'd195, 8'd13, 8'd203, 8'd9,
        8'd47, 8'd104, 8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203,
        8'd181, 8'd235, 8'd193, 8'd206, 8'd70, 8'd180, 8'd174, 8'd0,
        8'd167, 8'd181, 8'd41, 8'd164, 8'd30, 8'd116, 8'd127, 8'd198,
        8'd245, 8'd146, 8'd87, 8'd224, 8'd149, 8'd206, 8'd57, 8'd4,
        8'd192, 8'd210, 8'd65, 8'd210, 8'd129, 8'd240, 8'd178, 8'd105,
        8'd228, 8'd108, 8'd245, 8'd148, 8'd140, 8'd40, 8'd35, 8'd195,
        8'd38, 8'd58, 8'd65, 8'd207, 8'd215, 8'd253, 8'd65, 8'd85,
        8'd208, 8'd76, 8'd62, 8'd3, 8'd237, 8'd55, 8'd89, 8'd232,
        8'd50, 8'd217, 8'd64, 8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
        8'd90, 8'd17, 8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187,
        8'd234, 8'd177, 8'd73, 8'd174, 8'd193, 8'd100, 8'd192, 8'd143,
        8'd97, 8'd53, 8'd145, 8'd135, 8'd19, 8'd103, 8'd13, 8'd90,
        8'd135, 8'd151, 8'd199, 8'd91, 8'd239, 8'd247, 8'd33, 8'd39,
        8'd145, 8'd101, 8'd120, 8'd99, 8'd3, 8'd186, 8'd86, 8'd99,
        8'd41, 8'd237, 8'd203, 8'd111, 8'd79, 8'd220, 8'd135, 8'd158,
        8'd42, 8'd30, 8'd154, 8'd120, 8'd67, 8'd87, 8'd167, 8'd135,
        8'd176, 8'd183, 8'd191, 8'd253, 8'd115, 8'd184, 8'd21, 8'd233,
        8'd58, 8'd129, 8'd233, 8'd142, 8'd39, 8'd128, 8'd211, 8'd118,
        8'd137, 8'd139, 8'd255, 8'd114, 8'd20, 8'd218, 8'd113, 8'd154,
        8'd27, 8'd127, 8'd246, 8'd250, 8'd1, 8'd8, 8'd198, 8'd250,
        8'd209, 8'd92, 8'd222, 8'd173, 8'd21, 8'd88, 8'd102, 8'd219
    };

    // floor(2^32 / (2^n - 1)); n = 0 never reaches the divider
    function automatic logic [32:0] recip(input logic [4:0] n);
        logic [32:0] r;
        unique case (n)
            5'd1:    r = 33'd4294967296;
            5'd2:    r = 33'd1431655765;
            5'd3:    r = 33'd613566756;
            5'd4:    r = 33'd286331153;
            5'd5:    r = 33'd138547332;
            5'd6:    r = 33'd68174084;
            5'd7:    r = 33'd33818640;
            5'd8:    r = 33'd16843009;
            5'd9:    r = 33'd8405024;
            5'd10:   r = 33'd4198404;
            5'd11:   r = 33'd2098176;
            5'd12:   r = 33'd1048832;
            5'd13:   r = 33'd524352;
            5'd14:   r = 33'd262160;
            5'd15:   r = 33'd131076;
            5'd16:   r = 33'd65537;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

>>> design/value_noise_2d_octaves_core.sv
// ----------------------------------------------------------------------------
// value_noise_2d_octaves_core
// Fractal 2D value noise: one signed Q16.16 point in, one Q0.16 noise item out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid/in_stall with coord_x, coord_y (signed Q16.16).
//   Output channel: out_valid/out_stall with noise_value (unsigned Q0.16).
//   An item moves on a rising edge where valid is high and stall is low.
//   Pipeline: twelve register stages from acceptance to the output register,
//   the first loaded on the accepting edge.
//   Throughput: one item per cycle; the octave lanes run side by side and
//   every stage is one register deep, so the pipeline takes a new item each
//   clock while it is not stalled.
//   Stall: when the output holds an item and out_stall is high, the whole
//   pipeline freezes and in_stall rises; nothing is lost or repeated, and
//   the pipeline moves again as soon as the output drains.
//   Configuration: cfg_we writes frequency (index 0, Q8.16) or octaves
//   (index 1); write only while the pipeline is empty.
//   Reset: clears all valid bits and loads frequency 1.0 and four octaves.
// ----------------------------------------------------------------------------
module value_noise_2d_octaves_core #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] coord_x,
    input  logic [31:0] coord_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] noise_value,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data
);

    // input reg, point multiply, 4 lane stages, 6 normalizer stages
    localparam int LAT = 12;

    logic        adv;
    logic [LAT-1:0] vld_reg, vld_next;

    logic [23:0] freq_reg;
    logic [3:0]  oct_reg;
    logic [4:0]  n_oct;

    logic        neg;
    logic [31:0] mag_x_reg, mag_y_reg;
    logic [24:0] feff_reg;
    logic [56:0] prod_x, prod_y;
    vn2o_pkg::point_t px_reg, py_reg;

    logic [MAX_OCTAVES-1:0][39:0] oct_value;

    // freeze everything while a finished item waits at a stalled output
    assign adv      = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !adv;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            freq_reg <= vn2o_pkg::FREQ_RESET;
            oct_reg  <= vn2o_pkg::OCTAVES_RESET;
        end
        else
        begin
            if (adv)
                vld_reg <= vld_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    vn2o_pkg::REG_FREQUENCY: freq_reg <= cfg_data;
                    vn2o_pkg::REG_OCTAVES:   oct_reg  <= cfg_data[3:0];
                    default:                 freq_reg <= freq_reg;
                endcase
            end
        end
    end

    // saturate the octave count at the lane count
    assign n_oct = ({1'b0, oct_reg} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES)
                                                       : {1'b0, oct_reg};

    // any negative coordinate doubles the frequency once
    assign neg = coord_x[31] || coord_y[31];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_x_reg <= coord_x[31] ? (~coord_x + 32'd1) : coord_x;
            mag_y_reg <= coord_y[31] ? (~coord_y + 32'd1) : coord_y;
            feff_reg  <= neg ? {freq_reg, 1'b0} : {1'b0, freq_reg};
        end
    end

    // scaled point in Q8.32; cell bits above the low byte are dropped
    assign prod_x = mag_x_reg * feff_reg;
    assign prod_y = mag_y_reg * feff_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= prod_x[39:0];
            py_reg <= prod_y[39:0];
        end
    end

    for (genvar i = 0; i < MAX_OCTAVES; i++)
    begin : g_lane
        vn2o_octave #(
            .SHIFT (i)
        ) u_octave (
            .clk   (clk),
            .adv   (adv),
            .px    (px_reg),
            .py    (py_reg),
            .value (oct_value[i])
        );
    end

    vn2o_norm #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_norm (
        .clk       (clk),
        .adv       (adv),
        .n_oct     (n_oct),
        .oct_value (oct_value),
        .noise     (noise_value)
    );

    assign out_valid = vld_reg[LAT-1];

endmodule

>>> design/vn2o_octave.sv
// ----------------------------------------------------------------------------
// vn2o_octave
// One octave lane: lattice hash, smoothstep weights and bilinear blend,
// four register stages.
// ----------------------------------------------------------------------------
module vn2o_octave #(
    parameter int SHIFT = 0
) (
    input  logic             clk,
    input  logic             adv,
    input  vn2o_pkg::point_t px,
    input  vn2o_pkg::point_t py,
    output logic [39:0]      value
);

    vn2o_pkg::point_t sx;
    vn2o_pkg::point_t sy;
    logic [31:0] sqx_full;
    logic [31:0] sqy_full;

    // stage 1
    logic [7:0]  ix1_reg, ix1_next;
    logic [15:0] fx1_reg, fy1_reg;
    logic [15:0] sqx1_reg, sqy1_reg;
    logic [7:0]  row0_reg, row1_reg;

    // stage 2
    logic [17:0] facx;
    logic [17:0] facy;
    logic [33:0] wx_full;
    logic [33:0] wy_full;
    logic [16:0] wx2_reg, wy2_reg;
    logic [7:0]  c00_reg, c10_reg, c01_reg, c11_reg;
    logic [7:0]  ix_p1;

    // stage 3
    logic signed [9:0]  dlo;
    logic signed [9:0]  dhi;
    logic signed [27:0] lo_next, hi_next;
    logic signed [27:0] lo3_reg, hi3_reg;
    logic [16:0]        wy3_reg;

    // stage 4
    logic signed [27:0] dy;
    logic signed [44:0] v_next;
    logic [39:0]        v4_reg;

    // octave scaling: the point doubles per octave, wrapping in 40 bits
    assign sx = px << SHIFT;
    assign sy = py << SHIFT;
    assign ix1_next = sx[39:32];
    assign sqx_full = sx[31:16] * sx[31:16];
    assign sqy_full = sy[31:16] * sy[31:16];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ix1_reg  <= ix1_next;
            fx1_reg  <= sx[31:16];
            fy1_reg  <= sy[31:16];
            sqx1_reg <= sqx_full[31:16];
            sqy1_reg <= sqy_full[31:16];
            row0_reg <= vn2o_pkg::PERM_ROM[8'(sy[39:32] + vn2o_pkg::SEED_OFS)];
            row1_reg <= vn2o_pkg::PERM_ROM[8'(sy[39:32] + vn2o_pkg::SEED_OFS + 8'd1)];
        end
    end

    assign facx    = 18'd196608 - {1'b0, fx1_reg, 1'b0};
    assign facy    = 18'd196608 - {1'b0, fy1_reg, 1'b0};
    assign wx_full = sqx1_reg * facx;
    assign wy_full = sqy1_reg * facy;
    assign ix_p1   = ix1_reg + 8'd1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wx2_reg <= wx_full[32:16];
            wy2_reg <= wy_full[32:16];
            c00_reg <= vn2o_pkg::PERM_ROM[8'(row0_reg + ix1_reg)];
            c10_reg <= vn2o_pkg::PERM_ROM[8'(row0_reg + ix_p1)];
            c01_reg <= vn2o_pkg::PERM_ROM[8'(row1_reg + ix1_reg)];
            c11_reg <= vn2o_pkg::PERM_ROM[8'(row1_reg + ix_p1)];
        end
    end

    // blend along x
    assign dlo = $signed({2'b00, c10_reg}) - $signed({2'b00, c00_reg});
    assign dhi = $signed({2'b00, c11_reg}) - $signed({2'b00, c01_reg});
    assign lo_next = $signed({4'b0000, c00_reg, 16'h0000})
                   + $signed({1'b0, wx2_reg}) * dlo;
    assign hi_next = $signed({4'b0000, c01_reg, 16'h0000})
                   + $signed({1'b0, wx2_reg}) * dhi;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo3_reg <= lo_next;
            hi3_reg <= hi_next;
            wy3_reg <= wy2_reg;
        end
    end

    // blend along y
    assign dy     = hi3_reg - lo3_reg;
    assign v_next = $signed({lo3_reg, 16'h0000}) + $signed({1'b0, wy3_reg}) * dy;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v4_reg <= v_next[39:0];
        end
    end

    assign value = v4_reg;

endmodule

>>> design/vn2o_norm.sv
// ----------------------------------------------------------------------------
// vn2o_norm
// Octave weighting, registered adder tree and division by 2^24*(2^n-1)
// through a reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module vn2o_norm #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                         clk,
    input  logic                         adv,
    input  logic [4:0]                   n_oct,
    input  logic [MAX_OCTAVES-1:0][39:0] oct_value,
    output logic [15:0]                  noise
);

    // weighted sum reaches 255 * 2^32 * (2^n - 1), one bit past 40 + n - 1
    localparam int AW = 40 + MAX_OCTAVES;
    localparam int MW = AW - 24;
    localparam int G  = (MAX_OCTAVES + 3) / 4;

    logic [MAX_OCTAVES-1:0][AW-1:0] term_next, term_reg;
    logic [G-1:0][AW-1:0]           grp_next, grp_reg;
    logic [AW-1:0]                  sum_next, sum_reg;
    logic [MW-1:0]                  m4;
    logic [MW+32:0]                 prod;
    logic [MW-1:0]                  q5_reg, m5_reg;
    logic [MW-1:0]                  q6_reg, qd6_reg, m6_reg;
    logic [MW+MAX_OCTAVES-1:0]      qd_full;
    logic [MAX_OCTAVES-1:0]         dvs;
    logic [MW-1:0]                  rem;
    logic [MW-1:0]                  q_fix;
    logic [15:0]                    noise_reg, noise_next;

    // octave i weighs 2^(n-1-i); unused octaves drop out
    always_comb
    begin
        int amt;
        for (int i = 0; i < MAX_OCTAVES; i++)
        begin
            amt = int'(n_oct) - 1 - i;
            if (i < int'(n_oct))
                term_next[i] = AW'(oct_value[i]) << amt;
            else
                term_next[i] = '0;
        end
    end

    always_comb
    begin
        for (int g = 0; g < G; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < 4; k++)
            begin
                if (g * 4 + k < MAX_OCTAVES)
                    grp_next[g] = grp_next[g] + term_reg[g * 4 + k];
            end
        end
        sum_next = '0;
        for (int g = 0; g < G; g++)
            sum_next = sum_next + grp_reg[g];
    end

    assign m4      = sum_reg[AW-1:24];
    assign prod    = m4 * vn2o_pkg::recip(n_oct);
    assign dvs     = MAX_OCTAVES'((33'd1 << n_oct) - 33'd1);
    assign qd_full = q5_reg * dvs;
    assign rem     = m6_reg - qd6_reg;
    assign q_fix   = (rem >= MW'(dvs)) ? q6_reg + MW'(1) : q6_reg;
    assign noise_next = (n_oct == 5'd0) ? 16'd0 : q_fix[15:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            term_reg  <= term_next;
            grp_reg   <= grp_next;
            sum_reg   <= sum_next;
            q5_reg    <= prod[MW+31:32];
            m5_reg    <= m4;
            q6_reg    <= q5_reg;
            qd6_reg   <= qd_full[MW-1:0];
            m6_reg    <= m5_reg;
            noise_reg <= noise_next;
        end
    end

    assign noise = noise_reg;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fractal 2D value noise core. A directed table
// covers extremes, sign handling, lattice wrap and octave limits; random
// points follow under several frequency/octave settings and idling mixes.
// Items are checked against typed-in values or an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench;

    localparam int OCT_LIMIT = 8;
    localparam int SEG_ITEMS = 240;

    typedef struct {
        logic [23:0] freq;
        logic [3:0]  oct;
        logic [31:0] x;
        logic [31:0] y;
        bit          fixed;   // noise value is typed in below
        logic [15:0] noise;
    } point_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] noise_value;
    logic        cfg_we;
    logic        cfg_index;
    logic [23:0] cfg_data;

    // bench copy of the configuration registers
    logic [23:0] cur_freq;
    logic [3:0]  cur_oct;

    logic [15:0] noise_due[$];
    int          fail_count;
    int          sent_count;
    int          checked_count;
    int          write_count;
    int          idle_pct;
    int          stall_pct;
    bit          hold_req;

    value_noise_2d_octaves_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, well past the slowest legal run.
    initial
    begin
        #20ms;
        $display("TIMEOUT: %0d noise items still due", noise_due.size());
        $display("testbench: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    // smoothstep weight in Q0.16, truncated at both shifts
    function automatic longint smooth_weight(logic [15:0] s);
        longint unsigned sv;
        longint unsigned sq;
        sv = longint'(s);
        sq = (sv * sv) >> 16;
        return longint'((sq * (64'd196608 - 2 * sv)) >> 16);
    endfunction

    // hashed lattice corner value 0..255
    function automatic longint lattice_hash(logic [7:0] cx, logic [7:0] cy);
        logic [7:0] row;
        row = vn2o_pkg::PERM_ROM[8'(cy + vn2o_pkg::SEED_OFS)];
        return longint'(vn2o_pkg::PERM_ROM[8'(row + cx)]);
    endfunction

    function automatic longint lerp_exact(longint a, longint b, longint w);
        return a * 65536 + w * (b - a);
    endfunction

    // one octave at the given Q8.32 point, Q8.32 result
    function automatic longint octave_sample(vn2o_pkg::point_t px,
                                             vn2o_pkg::point_t py);
        logic [7:0] ix;
        logic [7:0] iy;
        longint     wx;
        longint     wy;
        longint     lo;
        longint     hi;
        ix = px[39:32];
        iy = py[39:32];
        wx = smooth_weight(px[31:16]);
        wy = smooth_weight(py[31:16]);
        lo = lerp_exact(lattice_hash(ix, iy), lattice_hash(ix + 8'd1, iy), wx);
        hi = lerp_exact(lattice_hash(ix, iy + 8'd1),
                        lattice_hash(ix + 8'd1, iy + 8'd1), wx);
        return lerp_exact(lo, hi, wy);
    endfunction

    function automatic logic [15:0] fractal_noise(logic [31:0] x, logic [31:0] y,
                                                  logic [23:0] fq, logic [3:0] oc);
        logic [24:0]      f;
        logic [31:0]      mx;
        logic [31:0]      my;
        vn2o_pkg::point_t px;
        vn2o_pkg::point_t py;
        longint unsigned  acc;
        int               n;
        f = {1'b0, fq};
        // a negative coordinate doubles the frequency once
        if (x[31] || y[31])
            f = f << 1;
        mx = x[31] ? -x : x;
        my = y[31] ? -y : y;
        px = vn2o_pkg::point_t'(64'(mx) * 64'(f));
        py = vn2o_pkg::point_t'(64'(my) * 64'(f));
        n = (int'(oc) > OCT_LIMIT) ? OCT_LIMIT : int'(oc);
        if (n == 0)
            return 16'd0;
        acc = 0;
        for (int i = 0; i < n; i++)
        begin
            acc += longint'(octave_sample(px, py)) << (n - 1 - i);
            px = px << 1;
            py = py << 1;
        end
        return 16'(acc / ((64'd1 << 24) * ((64'd1 << n) - 1)));
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (noise_due.size() == 0)
                report_mismatch($sformatf("unexpected noise item %0d", noise_value));
            else
            begin
                logic [15:0] want;
                want = noise_due.pop_front();
                if (noise_value !== want)
                    report_mismatch($sformatf("noise_value got %0d want %0d",
                                              noise_value, want));
                checked_count++;
            end
        end
    end

    // Receiver: random stall, or one long hold-off on request so the pipe fills.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                for (int k = 0; k < 400; k++)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ---------------------------------------------------------------- driving

    // Offer one point, hold it until taken, then queue its noise value.
    task automatic send_point(logic [31:0] x, logic [31:0] y, bit fixed,
                              logic [15:0] noise);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        coord_x  <= x;
        coord_y  <= y;
        do
            @(posedge clk);
        while (in_stall);
        noise_due.push_back(fixed ? noise : fractal_noise(x, y, cur_freq, cur_oct));
        sent_count++;
    endtask

    // Drain the pipe, then write one register.
    task automatic write_reg(logic idx, logic [23:0] value);
        in_valid <= 1'b0;
        while (noise_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == vn2o_pkg::REG_FREQUENCY)
            cur_freq = value;
        else
            cur_oct = value[3:0];
        write_count++;
    endtask

    task automatic set_config(logic [23:0] fq, logic [3:0] oc);
        if (fq != cur_freq)
            write_reg(vn2o_pkg::REG_FREQUENCY, fq);
        if (oc != cur_oct)
            write_reg(vn2o_pkg::REG_OCTAVES, {20'd0, oc});
    endtask

    function automatic logic [31:0] rand_coord();
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h003F_FFFF);
            2: v = -$urandom_range(0, 32'h003F_FFFF);
            default:
                case ($urandom_range(4))
                    0: v = 32'h0000_0000;
                    1: v = 32'hFFFF_FFFF;
                    2: v = 32'h7FFF_FFFF;
                    3: v = 32'h8000_0000;
                    default: v = 32'h00FF_0000 | $urandom_range(0, 16'hFFFF);
                endcase
        endcase
        return v;
    endfunction

    // ---------------------------------------------------------------- stimulus

    point_row_t directed[] = '{
        // origin: every octave reads the same corner, value 135 -> 135 * 256
        '{24'd65536,    4'd4,  32'h0000_0000, 32'h0000_0000, 1'b1, 16'd34560},
        '{24'd65536,    4'd4,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'd0},
        '{24'd65536,    4'd4,  32'h8000_0000, 32'h8000_0000, 1'b0, 16'd0},
        '{24'd65536,    4'd4,  32'h8000_0000, 32'h0000_0000, 1'b0, 16'd0},
        '{24'd65536,    4'd4,  32'h0000_0000, 32'h8000_0000, 1'b0, 16'd0},
        '{24'd65536,    4'd4,  32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 16'd0},
        '{24'd65536,    4'd4,  32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 16'd0},
        '{24'd65536,    4'd4,  32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 16'd0},
        '{24'd65536,    4'd4,  32'hFFFF_0000, 32'h0000_8000, 1'b0, 16'd0},
        // lattice wrap: cell 255 blends with cell 0
        '{24'd65536,    4'd4,  32'h00FF_8000, 32'h00FF_8000, 1'b0, 16'd0},
        '{24'd65536,    4'd4,  32'h00FF_FFFF, 32'h0001_0000, 1'b0, 16'd0},
        '{24'd65536,    4'd4,  32'h0000_FFFF, 32'h0000_8000, 1'b0, 16'd0},
        '{24'd65536,    4'd1,  32'h0003_4000, 32'h0012_C000, 1'b0, 16'd0},
        '{24'd65536,    4'd8,  32'h0003_4000, 32'h0012_C000, 1'b0, 16'd0},
        // above the octave limit: saturates at eight
        '{24'd65536,    4'd15, 32'h0003_4000, 32'h0012_C000, 1'b0, 16'd0},
        '{24'd65536,    4'd9,  32'hFFF1_2345, 32'h0ABC_DEF0, 1'b0, 16'd0},
        // no octaves: always zero
        '{24'd65536,    4'd0,  32'h1234_5678, 32'h8765_4321, 1'b1, 16'd0},
        '{24'd65536,    4'd0,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'd0},
        // zero frequency pins the point to the origin
        '{24'd0,        4'd4,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'd34560},
        '{24'hFF_FFFF,  4'd4,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'd0},
        '{24'hFF_FFFF,  4'd8,  32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 16'd0},
        '{24'hFF_FFFF,  4'd3,  32'h0000_0001, 32'h0000_0003, 1'b0, 16'd0},
        '{24'h80_0000,  4'd2,  32'hFFFF_8000, 32'h0000_4000, 1'b0, 16'd0}
    };

    initial
    begin
        logic [23:0] seg_freq;
        logic [3:0]  seg_oct;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        coord_x    = 32'd0;
        coord_y    = 32'd0;
        cfg_we     = 1'b0;
        cfg_index  = vn2o_pkg::REG_FREQUENCY;
        cfg_data   = 24'd0;
        cur_freq   = vn2o_pkg::FREQ_RESET;
        cur_oct    = vn2o_pkg::OCTAVES_RESET;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_req   = 1'b0;
        fail_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table under light idling.
        idle_pct  = 17;
        stall_pct = 17;
        foreach (directed[r])
        begin
            set_config(directed[r].freq, directed[r].oct);
            send_point(directed[r].x, directed[r].y, directed[r].fixed,
                       directed[r].noise);
        end

        // Random segments: each picks a setting and an idling mix.
        for (int seg = 0; seg < 8; seg++)
        begin
            case (seg)
                0: begin seg_freq = 24'd65536;  seg_oct = 4'd4; end
                1: begin seg_freq = 24'hFF_FFFF; seg_oct = 4'd8; end
                2: begin seg_freq = 24'd0;      seg_oct = 4'd1; end
                3: begin seg_freq = 24'($urandom); seg_oct = 4'd15; end
                4: begin seg_freq = 24'($urandom_range(0, 24'h04_0000));
                         seg_oct = 4'($urandom_range(0, 8)); end
                5: begin seg_freq = 24'h00_8000; seg_oct = 4'd2; end
                6: begin seg_freq = 24'($urandom);
                         seg_oct = 4'($urandom_range(0, 15)); end
                default: begin seg_freq = 24'($urandom_range(24'h01_0000, 24'h20_0000));
                               seg_oct = 4'($urandom_range(5, 8)); end
            endcase
            set_config(seg_freq, seg_oct);
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 83; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 83; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            // back-pressure: output held while the sender keeps streaming
            if (seg == 0)
                hold_req = 1'b1;
            for (int i = 0; i < SEG_ITEMS; i++)
                send_point(rand_coord(), rand_coord(), 1'b0, 16'd0);
        end

        in_valid <= 1'b0;
        for (int w = 0; w < 100000 && noise_due.size() != 0; w++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (noise_due.size() != 0)
            report_mismatch($sformatf("%0d noise items never arrived", noise_due.size()));

        $display("Run covered %0d points, %0d noise items checked, %0d register writes,",
                 sent_count, checked_count, write_count);
        $display("over frequency/octave extremes and four idle/stall mixes.");
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
